// ===== rtl/core/lla_pkg.sv =====
// Shared types and constants of the least-loaded vector allocator.
`default_nettype none

package lla_pkg;

  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 24;
  localparam int MASK_W  = 8;

  // Request kinds; the fourth code is reserved and rejected.
  localparam logic [1:0] KIND_AUTO     = 2'd0;
  localparam logic [1:0] KIND_GIVEN    = 2'd1;
  localparam logic [1:0] KIND_EXPLICIT = 2'd2;

  localparam logic [7:0]         FIRST_AUTO_BASE = 8'h30;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] processor;
    logic [7:0] base_vector;
    logic [7:0] group_size;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [2:0] chosen_processor;
    logic [7:0] chosen_vector;
  } out_t;

  // Control of the window accumulator, registered so that it lines up with the memory read data.
  typedef struct packed {
    logic       start;
    logic       valid;
    logic       sub;
    logic       cmp;
    logic [7:0] base;
  } win_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PICK,
    ST_PICK_LAST,
    ST_ROW,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_TAKE,
    ST_RANGE,
    ST_INC,
    ST_INC_LAST,
    ST_TOT_RD,
    ST_TOT_WR,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lla_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module lla_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lla_window.sv =====
// Sliding window sum over usage counts, keeping the lowest base of the smallest sum.
`default_nettype none

module lla_window #(
  parameter int MAX_GROUP = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lla_pkg::win_ctl_t             ctl,
  input  wire logic [lla_pkg::COUNT_W-1:0]   rd_add,
  input  wire logic [lla_pkg::COUNT_W-1:0]   rd_sub,
  output logic      [7:0]                    best_base
);

  localparam int SW = lla_pkg::COUNT_W + $clog2(MAX_GROUP + 1);

  logic [SW-1:0] sum_r;
  logic [SW-1:0] best_r;
  logic [SW-1:0] sum_nxt;
  logic          found_r;
  logic [7:0]    best_base_r;

  // The count leaving the window is subtracted once the window is full.
  assign sum_nxt = sum_r + SW'(rd_add) - (ctl.sub ? SW'(rd_sub) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (ctl.valid && ctl.cmp) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sum_r       <= '0;
      best_base_r <= lla_pkg::FIRST_AUTO_BASE;
    end else if (ctl.valid) begin
      sum_r <= sum_nxt;
      // Strict compare: on a tie the earlier base stays.
      if (ctl.cmp && (!found_r || sum_nxt < best_r)) begin
        best_r      <= sum_nxt;
        best_base_r <= ctl.base;
      end
    end
  end

  assign best_base = best_base_r;

endmodule

`default_nettype wire

// ===== rtl/core/least_loaded_vector_allocator_top.sv =====
// Top level of the least-loaded vector allocator: sequencer and its two memories.
// An automatic base adds a window scan over the row to explicit placement, and an automatic
// processor adds a scan of the totals of the first eight processors.
// Throughput: one request at a time; the next word can be taken in the cycle after a result loads.
// Reset: synchronous, active low; the memories are then cleared entry by entry.
`default_nettype none

module least_loaded_vector_allocator_top #(
  parameter int NUM_PROCESSORS = 8,
  parameter int VECTOR_SLOTS   = 255,
  parameter int MAX_GROUP      = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lla_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lla_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lla_pkg::MASK_W-1:0]  cfg_data
);

  // Usage counts live in one memory, one row of VECTOR_SLOTS entries per processor.
  localparam int VD   = NUM_PROCESSORS * VECTOR_SLOTS;
  localparam int VA_W = $clog2(VD);
  localparam int TA_W = (NUM_PROCESSORS > 1) ? $clog2(NUM_PROCESSORS) : 1;
  // Only the first eight processors can be chosen automatically.
  localparam int PN   = (NUM_PROCESSORS < 8) ? NUM_PROCESSORS : 8;

  lla_pkg::state_t state_r, state_nxt;

  // Configuration register; the user must write it only while idle, the block does not enforce this.
  logic [lla_pkg::MASK_W-1:0] mask_r;

  // Request being worked on.
  logic [1:0]       kind_r;
  logic [2:0]       proc_r;
  logic [7:0]       base_r;
  logic [7:0]       size_r;
  logic             bad_r;
  logic             req_bad;
  logic [VA_W-1:0]  row_r;
  logic [VA_W-1:0]  clr_r;

  // Processor scan.
  logic [2:0]                  pc_r;
  logic                        pk_v_r;
  logic [2:0]                  pk_idx_r;
  logic                        pfound_r;
  logic [2:0]                  pbest_r;
  logic [2:0]                  pbest_nxt;
  logic [lla_pkg::TOTAL_W-1:0] pbest_tot_r;
  logic                        pk_take;

  // Window scan and increment pass.
  logic [7:0]        a_r;
  logic [7:0]        i_r;
  logic [VA_W-1:0]   vaddr_r;
  logic              inc_v_r;
  logic [VA_W-1:0]   inc_addr_r;
  lla_pkg::win_ctl_t win_ctl_r;
  logic [7:0]        win_best_base;
  logic              scan_go;

  // Memory ports.
  logic                        vec_we;
  logic [VA_W-1:0]             vec_waddr;
  logic [lla_pkg::COUNT_W-1:0] vec_wdata;
  logic [VA_W-1:0]             vec_raddr_a;
  logic [VA_W-1:0]             vec_raddr_b;
  logic [lla_pkg::COUNT_W-1:0] vec_rdata_a;
  logic [lla_pkg::COUNT_W-1:0] vec_rdata_b;
  logic                        tot_we;
  logic [TA_W-1:0]             tot_waddr;
  logic [lla_pkg::TOTAL_W-1:0] tot_wdata;
  logic [TA_W-1:0]             tot_raddr;
  logic [lla_pkg::TOTAL_W-1:0] tot_rdata;
  logic [lla_pkg::TOTAL_W:0]   tot_sum;
  logic                        range_bad;

  // Output register: a finished result waits here while the next word may be taken.
  logic          out_valid_r;
  lla_pkg::out_t out_data_r;
  logic          out_load;

  // ---------------------------------------------------------------------------
  // Request checks that do not depend on the stored state.
  // ---------------------------------------------------------------------------
  always_comb begin
    req_bad = 1'b0;
    if (kind_r != lla_pkg::KIND_AUTO && kind_r != lla_pkg::KIND_GIVEN &&
        kind_r != lla_pkg::KIND_EXPLICIT) begin
      req_bad = 1'b1;
    end
    if (size_r == 8'd0) begin
      req_bad = 1'b1;
    end
    if (kind_r != lla_pkg::KIND_EXPLICIT && int'(size_r) > MAX_GROUP) begin
      req_bad = 1'b1;
    end
    if (kind_r != lla_pkg::KIND_AUTO && int'(proc_r) >= NUM_PROCESSORS) begin
      req_bad = 1'b1;
    end
  end

  // The window is scanned only when the last base lies above 0x30; otherwise base 0x30 is used.
  assign scan_go   = (VECTOR_SLOTS - int'(size_r)) > int'(lla_pkg::FIRST_AUTO_BASE);
  assign range_bad = (int'(base_r) + int'(size_r)) > VECTOR_SLOTS;

  // The lowest enabled processor with the smallest total wins; ties keep the earlier one.
  assign pk_take   = pk_v_r && mask_r[pk_idx_r] && (!pfound_r || tot_rdata < pbest_tot_r);
  assign pbest_nxt = pk_take ? pk_idx_r : pbest_r;

  assign tot_sum   = {1'b0, tot_rdata} + (lla_pkg::TOTAL_W + 1)'(size_r);
  assign out_load  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lla_pkg::ST_CLEAR: begin
        if (clr_r == VA_W'(VD - 1)) begin
          state_nxt = lla_pkg::ST_IDLE;
        end
      end
      lla_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lla_pkg::ST_CHECK;
        end
      end
      lla_pkg::ST_CHECK: begin
        if (req_bad) begin
          state_nxt = lla_pkg::ST_RESULT;
        end else if (kind_r == lla_pkg::KIND_AUTO) begin
          state_nxt = lla_pkg::ST_PICK;
        end else begin
          state_nxt = lla_pkg::ST_ROW;
        end
      end
      lla_pkg::ST_PICK: begin
        if (pc_r == 3'(PN - 1)) begin
          state_nxt = lla_pkg::ST_PICK_LAST;
        end
      end
      lla_pkg::ST_PICK_LAST: begin
        state_nxt = lla_pkg::ST_ROW;
      end
      lla_pkg::ST_ROW: begin
        if (kind_r == lla_pkg::KIND_EXPLICIT || !scan_go) begin
          state_nxt = lla_pkg::ST_RANGE;
        end else begin
          state_nxt = lla_pkg::ST_SCAN;
        end
      end
      lla_pkg::ST_SCAN: begin
        if (a_r == 8'(VECTOR_SLOTS - 2)) begin
          state_nxt = lla_pkg::ST_SCAN_LAST;
        end
      end
      lla_pkg::ST_SCAN_LAST: begin
        state_nxt = lla_pkg::ST_TAKE;
      end
      lla_pkg::ST_TAKE: begin
        state_nxt = lla_pkg::ST_RANGE;
      end
      lla_pkg::ST_RANGE: begin
        state_nxt = range_bad ? lla_pkg::ST_RESULT : lla_pkg::ST_INC;
      end
      lla_pkg::ST_INC: begin
        if (i_r == size_r - 8'd1) begin
          state_nxt = lla_pkg::ST_INC_LAST;
        end
      end
      lla_pkg::ST_INC_LAST: begin
        state_nxt = lla_pkg::ST_TOT_RD;
      end
      lla_pkg::ST_TOT_RD: begin
        state_nxt = lla_pkg::ST_TOT_WR;
      end
      lla_pkg::ST_TOT_WR: begin
        state_nxt = lla_pkg::ST_RESULT;
      end
      lla_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = lla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lla_pkg::ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: memory ports and the input stall.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall    = 1'b1;
    vec_we      = 1'b0;
    vec_waddr   = inc_addr_r;
    vec_wdata   = (vec_rdata_a == lla_pkg::COUNT_MAX) ? vec_rdata_a
                                                      : vec_rdata_a + 16'd1;
    vec_raddr_a = vaddr_r;
    vec_raddr_b = row_r + VA_W'(a_r) - VA_W'(size_r);
    tot_we      = 1'b0;
    tot_waddr   = TA_W'(proc_r);
    tot_wdata   = tot_sum > {1'b0, lla_pkg::TOTAL_MAX} ? lla_pkg::TOTAL_MAX
                                                       : tot_sum[lla_pkg::TOTAL_W-1:0];
    tot_raddr   = TA_W'(proc_r);
    unique case (state_r)
      lla_pkg::ST_CLEAR: begin
        vec_we    = 1'b1;
        vec_waddr = clr_r;
        vec_wdata = '0;
        tot_we    = int'(clr_r) < NUM_PROCESSORS;
        tot_waddr = TA_W'(clr_r);
        tot_wdata = '0;
      end
      lla_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lla_pkg::ST_PICK: begin
        tot_raddr = TA_W'(pc_r);
      end
      lla_pkg::ST_SCAN: begin
        vec_raddr_a = row_r + VA_W'(a_r);
      end
      lla_pkg::ST_INC, lla_pkg::ST_INC_LAST: begin
        vec_we = inc_v_r;
      end
      lla_pkg::ST_TOT_WR: begin
        tot_we = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lla_pkg::ST_CLEAR;
      clr_r       <= '0;
      mask_r      <= 8'd1;
      out_valid_r <= 1'b0;
      pk_v_r      <= 1'b0;
      inc_v_r     <= 1'b0;
      win_ctl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lla_pkg::ST_CLEAR) begin
        clr_r <= clr_r + VA_W'(1);
      end
      if (cfg_valid) begin
        mask_r <= cfg_data;
      end
      if (state_r == lla_pkg::ST_RESULT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pk_v_r  <= state_r == lla_pkg::ST_PICK;
      inc_v_r <= state_r == lla_pkg::ST_INC;
      // The window unit sees each scan read in the cycle after it was issued.
      win_ctl_r.start <= state_r == lla_pkg::ST_ROW;
      win_ctl_r.valid <= state_r == lla_pkg::ST_SCAN;
      win_ctl_r.sub   <= {1'b0, a_r} >= ({1'b0, lla_pkg::FIRST_AUTO_BASE} + {1'b0, size_r});
      win_ctl_r.cmp   <= ({1'b0, a_r} + 9'd1) >=
                         ({1'b0, lla_pkg::FIRST_AUTO_BASE} + {1'b0, size_r});
      win_ctl_r.base  <= a_r - size_r + 8'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pk_v_r) begin
      pbest_r <= pbest_nxt;
      if (pk_take) begin
        pfound_r    <= 1'b1;
        pbest_tot_r <= tot_rdata;
      end
    end
    pk_idx_r   <= pc_r;
    inc_addr_r <= vaddr_r;
    case (state_r)
      lla_pkg::ST_IDLE: begin
        kind_r <= in_data.kind;
        proc_r <= in_data.processor;
        base_r <= in_data.base_vector;
        size_r <= in_data.group_size;
      end
      lla_pkg::ST_CHECK: begin
        bad_r    <= req_bad;
        pc_r     <= '0;
        pfound_r <= 1'b0;
        pbest_r  <= '0;
      end
      lla_pkg::ST_PICK: begin
        pc_r <= pc_r + 3'd1;
      end
      lla_pkg::ST_PICK_LAST: begin
        proc_r <= pbest_nxt;
      end
      lla_pkg::ST_ROW: begin
        row_r <= VA_W'(int'(proc_r) * VECTOR_SLOTS);
        a_r   <= lla_pkg::FIRST_AUTO_BASE;
        if (kind_r != lla_pkg::KIND_EXPLICIT) begin
          base_r <= lla_pkg::FIRST_AUTO_BASE;
        end
      end
      lla_pkg::ST_SCAN: begin
        a_r <= a_r + 8'd1;
      end
      lla_pkg::ST_TAKE: begin
        base_r <= win_best_base;
      end
      lla_pkg::ST_RANGE: begin
        bad_r   <= range_bad;
        vaddr_r <= row_r + VA_W'(base_r);
        i_r     <= '0;
      end
      lla_pkg::ST_INC: begin
        vaddr_r <= vaddr_r + VA_W'(1);
        i_r     <= i_r + 8'd1;
      end
      lla_pkg::ST_RESULT: begin
        if (out_load) begin
          out_data_r.status           <= bad_r;
          out_data_r.chosen_processor <= bad_r ? 3'd0 : proc_r;
          out_data_r.chosen_vector    <= bad_r ? 8'd0 : base_r;
        end
      end
      default: begin
        row_r <= row_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Memories and the window unit.
  // ---------------------------------------------------------------------------
  lla_ram #(
    .WIDTH (lla_pkg::COUNT_W),
    .DEPTH (VD)
  ) u_usage_ram (
    .clk     (clk),
    .we      (vec_we),
    .waddr   (vec_waddr),
    .wdata   (vec_wdata),
    .raddr_a (vec_raddr_a),
    .rdata_a (vec_rdata_a),
    .raddr_b (vec_raddr_b),
    .rdata_b (vec_rdata_b)
  );

  lla_ram #(
    .WIDTH (lla_pkg::TOTAL_W),
    .DEPTH (NUM_PROCESSORS)
  ) u_total_ram (
    .clk     (clk),
    .we      (tot_we),
    .waddr   (tot_waddr),
    .wdata   (tot_wdata),
    .raddr_a (tot_raddr),
    .rdata_a (tot_rdata),
    .raddr_b (tot_raddr),
    .rdata_b ()
  );

  lla_window #(
    .MAX_GROUP (MAX_GROUP)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl_r),
    .rd_add    (vec_rdata_a),
    .rd_sub    (vec_rdata_b),
    .best_base (win_best_base)
  );

`ifndef ASSERT_OFF
  // A new result word only ever comes out of the result state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == lla_pkg::ST_RESULT)
    else $error("result word appeared outside the result state");

  // The usage memory is not written while it is being scanned.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lla_pkg::ST_SCAN || state_r == lla_pkg::ST_SCAN_LAST ||
     state_r == lla_pkg::ST_TAKE) |-> !vec_we)
    else $error("usage memory written during window scan");

  // Incrementing only starts for a group that fits in the row.
  a_inc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lla_pkg::ST_INC && $past(state_r) == lla_pkg::ST_RANGE) |->
    (int'(base_r) + int'(size_r)) <= VECTOR_SLOTS)
    else $error("group placed past the end of the row");

  // No request is taken before the clearing pass is over.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lla_pkg::ST_CLEAR |-> in_stall)
    else $error("input accepted during the clearing pass");
`endif

endmodule

`default_nettype wire
